// ----- rtl/adsr_pkg.sv -----
package adsr_pkg;

	localparam int TIME_W = 32;
	localparam int LEN_W  = 24;
	localparam int LVL_W  = 16;
	localparam int END_W  = LEN_W + 2;
	localparam int PROD_W = LVL_W + LEN_W;
	localparam int QUO_W  = 16;
	localparam int CNT_W  = $clog2(QUO_W);
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 24;

	localparam logic [LVL_W-1:0] FULL_SCALE = 16'd32768;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_ATTACK  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_DECAY   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_HOLD    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_RELEASE = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_SUSTAIN = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_REPEAT  = 3'd5;

	localparam logic [LEN_W-1:0] ATTACK_RST  = 24'd4800;
	localparam logic [LEN_W-1:0] DECAY_RST   = 24'd4800;
	localparam logic [LEN_W-1:0] HOLD_RST    = 24'd24000;
	localparam logic [LEN_W-1:0] RELEASE_RST = 24'd4800;
	localparam logic [LVL_W-1:0] SUSTAIN_RST = 16'd16384;

	typedef enum logic [2:0] {
		STG_ATTACK,
		STG_DECAY,
		STG_SUSTAIN,
		STG_RELEASE,
		STG_DONE
	} stage_t;

	typedef struct packed {
		logic load_in;
		logic calc_ends;
		logic classify;
		logic mul;
		logic div_step;
		logic finish;
	} dp_cmd_t;

	typedef struct packed {
		logic need_div;
	} dp_stat_t;

endpackage

// ----- rtl/adsr_dpath.sv -----
module adsr_dpath (
	input  logic                             clk,
	input  logic                             arst_n,
	input  adsr_pkg::dp_cmd_t                cmd,
	output adsr_pkg::dp_stat_t               stat,
	input  logic [adsr_pkg::TIME_W-1:0]      sample_time,
	input  logic [adsr_pkg::LEN_W-1:0]       attack_len,
	input  logic [adsr_pkg::LEN_W-1:0]       decay_len,
	input  logic [adsr_pkg::LEN_W-1:0]       hold_len,
	input  logic [adsr_pkg::LEN_W-1:0]       release_len,
	input  logic [adsr_pkg::LVL_W-1:0]       sustain_level,
	input  logic                             repeat_mode,
	output logic [adsr_pkg::LVL_W-1:0]       level,
	output logic                             alive
);
	import adsr_pkg::*;

	logic [TIME_W-1:0] start_q;
	logic              started_q;
	logic [TIME_W-1:0] now_q;
	logic [TIME_W-1:0] e_q;
	logic [END_W-1:0]  a_end_q, d_end_q, h_end_q, r_end_q;

	stage_t            stage_q, stage_d;
	logic [LEN_W-1:0]  off_q, off_d;
	logic [LVL_W-1:0]  m_q, m_d;
	logic [LEN_W-1:0]  len_q, len_d;
	logic [LVL_W-1:0]  s_q, s_clamp;
	logic              alive_s;

	logic [PROD_W-1:0] num_q, den_q, prod;
	logic [QUO_W-1:0]  quo_q;
	logic [LVL_W-1:0]  level_d;
	logic [TIME_W-1:0] diff_a, diff_h;

	assign s_clamp = (sustain_level > FULL_SCALE) ? FULL_SCALE : sustain_level;
	assign diff_a  = e_q - TIME_W'(a_end_q);
	assign diff_h  = e_q - TIME_W'(h_end_q);

	// stage selection from elapsed time
	always_comb begin
		stage_d = STG_DONE;
		off_d   = '0;
		m_d     = '0;
		len_d   = '0;
		if (e_q < TIME_W'(a_end_q)) begin
			stage_d = STG_ATTACK;
			off_d   = e_q[LEN_W-1:0];
			m_d     = FULL_SCALE;
			len_d   = attack_len;
		end else if (e_q < TIME_W'(d_end_q)) begin
			stage_d = STG_DECAY;
			off_d   = diff_a[LEN_W-1:0];
			m_d     = FULL_SCALE - s_clamp;
			len_d   = decay_len;
		end else if (e_q < TIME_W'(h_end_q)) begin
			stage_d = STG_SUSTAIN;
		end else if (e_q < TIME_W'(r_end_q)) begin
			stage_d = STG_RELEASE;
			off_d   = diff_h[LEN_W-1:0];
			m_d     = s_clamp;
			len_d   = release_len;
		end
	end

	assign prod = {{LEN_W{1'b0}}, m_q} * {{LVL_W{1'b0}}, off_q};

	always_comb begin
		case (stage_q)
			STG_ATTACK:  level_d = quo_q;
			STG_DECAY:   level_d = FULL_SCALE - quo_q;
			STG_SUSTAIN: level_d = s_q;
			STG_RELEASE: level_d = s_q - quo_q;
			default:     level_d = '0;
		endcase
	end

	assign stat.need_div = (stage_q == STG_ATTACK) || (stage_q == STG_DECAY) ||
		(stage_q == STG_RELEASE);

	// envelope start time and registered stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_q   <= '0;
			started_q <= 1'b0;
			stage_q   <= STG_DONE;
		end else begin
			if (cmd.load_in && !started_q) begin
				started_q <= 1'b1;
				start_q   <= sample_time;
			end else if (cmd.finish && repeat_mode && level_d == '0) begin
				start_q <= now_q;
			end
			if (cmd.classify)
				stage_q <= stage_d;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			now_q <= sample_time;
			e_q   <= started_q ? (sample_time - start_q) : '0;
		end
		if (cmd.calc_ends) begin
			a_end_q <= END_W'(attack_len);
			d_end_q <= END_W'(attack_len) + END_W'(decay_len);
			h_end_q <= END_W'(attack_len) + END_W'(decay_len) + END_W'(hold_len);
			r_end_q <= END_W'(attack_len) + END_W'(decay_len) + END_W'(hold_len)
				+ END_W'(release_len);
		end
		if (cmd.classify) begin
			off_q   <= off_d;
			m_q     <= m_d;
			len_q   <= len_d;
			s_q     <= s_clamp;
			alive_s <= repeat_mode || (e_q < TIME_W'(r_end_q));
		end
		// restoring divider, one quotient bit per cycle
		if (cmd.mul) begin
			num_q <= prod;
			den_q <= {1'b0, len_q, {(QUO_W-1){1'b0}}};
			quo_q <= '0;
		end else if (cmd.div_step) begin
			if (num_q >= den_q) begin
				num_q <= num_q - den_q;
				quo_q <= {quo_q[QUO_W-2:0], 1'b1};
			end else begin
				quo_q <= {quo_q[QUO_W-2:0], 1'b0};
			end
			den_q <= den_q >> 1;
		end
		if (cmd.finish) begin
			level <= level_d;
			alive <= alive_s;
		end
	end

	a_rel_below_sustain: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish && stage_q == STG_RELEASE |-> level_d <= s_q)
		else $error("release level above sustain");

	a_quo_range: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish && stat.need_div |-> !quo_q[QUO_W-1])
		else $error("ramp quotient out of range");

	a_alive_stage: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.classify && !repeat_mode |=> alive_s == (stage_q != STG_DONE))
		else $error("alive disagrees with stage");

endmodule

// ----- rtl/adsr_ctrl.sv -----
module adsr_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	output logic                out_valid,
	input  logic                out_stall,
	output adsr_pkg::dp_cmd_t   cmd,
	input  adsr_pkg::dp_stat_t  stat
);
	import adsr_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE,
		S_ENDS,
		S_CLASS,
		S_MUL,
		S_DIV,
		S_FIN
	} state_t;

	state_t           state_q;
	logic [CNT_W-1:0] cnt_q;
	logic             out_valid_q;

	assign in_stall  = (state_q != S_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		cmd.load_in   = (state_q == S_IDLE) && in_valid;
		cmd.calc_ends = (state_q == S_ENDS);
		cmd.classify  = (state_q == S_CLASS);
		cmd.mul       = (state_q == S_MUL);
		cmd.div_step  = (state_q == S_DIV);
		cmd.finish    = (state_q == S_FIN) && (!out_valid_q || !out_stall);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.finish)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (in_valid)
						state_q <= S_ENDS;
				end
				S_ENDS:  state_q <= S_CLASS;
				S_CLASS: state_q <= S_MUL;
				S_MUL: begin
					cnt_q   <= '0;
					state_q <= stat.need_div ? S_DIV : S_FIN;
				end
				S_DIV: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == CNT_W'(QUO_W - 1))
						state_q <= S_FIN;
				end
				S_FIN: begin
					if (!out_valid_q || !out_stall)
						state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> state_q == S_ENDS)
		else $error("accepted item did not start");

	a_finish_shows: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |=> out_valid_q && state_q == S_IDLE)
		else $error("result not presented after finish");

	a_div_len: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_DIV && cnt_q == CNT_W'(QUO_W - 1) |=> state_q == S_FIN)
		else $error("divider ran past its last step");

endmodule

// ----- rtl/adsr_envelope_generator.sv -----
// linear adsr envelope generator
// input channel: in_valid / in_stall with sample_time, the absolute sample index
//   of the wanted output sample; one transfer happens on an edge with in_valid
//   high and in_stall low
// output channel: out_valid / out_stall with level (q1.15, 32768 = 1.0) and
//   alive; exactly one result per input transfer, in order
// config channel: cfg_valid / cfg_ready with cfg_index and cfg_data, write only
//   while the block is idle; cfg_ready is always high
//   0 attack_len, 1 decay_len, 2 hold_len, 3 release_len, 4 sustain_level,
//   5 repeat_mode; other indexes are ignored
// sequence: one item at a time; after the input transfer the block computes the
//   stage ends, classifies, multiplies and loads the result; for ramp stages
//   the 16-step serial divider that forms each ramp quotient runs before the
//   load; in_stall drops at the same edge that loads the result
// the first item after reset latches the envelope start; in repeat mode a zero
//   level restarts the envelope at that item's time
// reset: configuration registers go to their package defaults, no result pending
// a stalled result sits in the output register; the block finishes the next
//   item and then waits until the output register frees up
module adsr_envelope_generator (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic [adsr_pkg::TIME_W-1:0]         sample_time,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic [adsr_pkg::LVL_W-1:0]          level,
	output logic                                alive,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [adsr_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [adsr_pkg::CFG_DATA_W-1:0]     cfg_data
);
	import adsr_pkg::*;

	logic [LEN_W-1:0] attack_q, decay_q, hold_q, release_q;
	logic [LVL_W-1:0] sustain_q;
	logic             repeat_q;

	dp_cmd_t  cmd;
	dp_stat_t stat;

	assign cfg_ready = 1'b1;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			attack_q  <= ATTACK_RST;
			decay_q   <= DECAY_RST;
			hold_q    <= HOLD_RST;
			release_q <= RELEASE_RST;
			sustain_q <= SUSTAIN_RST;
			repeat_q  <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_ATTACK:  attack_q  <= cfg_data[LEN_W-1:0];
				CFG_DECAY:   decay_q   <= cfg_data[LEN_W-1:0];
				CFG_HOLD:    hold_q    <= cfg_data[LEN_W-1:0];
				CFG_RELEASE: release_q <= cfg_data[LEN_W-1:0];
				CFG_SUSTAIN: sustain_q <= cfg_data[LVL_W-1:0];
				CFG_REPEAT:  repeat_q  <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// sequencer: ends, classify, multiply, divide (ramp stages only), finish
	adsr_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.cmd       (cmd),
		.stat      (stat)
	);

	// elapsed time, stage select, ramp multiply and serial divide
	adsr_dpath u_dpath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.stat          (stat),
		.sample_time   (sample_time),
		.attack_len    (attack_q),
		.decay_len     (decay_q),
		.hold_len      (hold_q),
		.release_len   (release_q),
		.sustain_level (sustain_q),
		.repeat_mode   (repeat_q),
		.level         (level),
		.alive         (alive)
	);

endmodule
